// ===== sv/pps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants for the priority scheduler
// Slot record held by each cell, control groups and the sequencer states.
// ----------------------------------------------------------------------------
package pps_pkg;

   // widths fixed by the item fields
   localparam int FIELD_W   = 8;
   localparam int OUT_W     = 13;
   localparam int SUM_W     = 17;
   localparam int IDX_OUT_W = 4;
   // load-order tag; covers sets of up to 64 processes
   localparam int TAG_W     = 6;

   // one process as held in a cell
   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [FIELD_W-1:0] burst;
      logic [FIELD_W-1:0] arrival;
      logic [FIELD_W-1:0] prio;
      logic [FIELD_W-1:0] remaining;
   } slot_type;

   // strobes broadcast to every cell
   typedef struct packed {
      logic load;
      logic clear;
      logic run;
   } cell_ctl_type;

   // strobes to the result store
   typedef struct packed {
      logic wr_en;
      logic latch;
      logic clear_totals;
      logic last;
   } rpt_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_RUN   = 5'b00010,
      ST_READ  = 5'b00100,
      ST_LATCH = 5'b01000,
      ST_SHOW  = 5'b10000
   } state_type;

endpackage

// ===== sv/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// In idle a request item is taken whenever one is offered; a closing item then
//   starts the tick loop, one simulated tick per cycle until the last process
//   finishes, and each result then passes through the read, latch and show
//   states, held in show while rsp_ready is low. No new set is taken until then.
// Reset: clears the counters, the cell valid bits and the sequencer; the
//   completion store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: priority scheduling over a chain of cells
// Loads a set of processes into a priority-sorted cell chain, simulates unit
// ticks with preemption, then reports turnaround and waiting in load order.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
   parameter int MAX_PROCS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_burst_time,
   input  logic [7:0]                      req_arrival_time,
   input  logic [7:0]                      req_priority_req,
   input  logic                            req_last_process,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pps_pkg::IDX_OUT_W-1:0]   rsp_process_index,
   output logic [pps_pkg::OUT_W-1:0]       rsp_waiting_time,
   output logic [pps_pkg::OUT_W-1:0]       rsp_turnaround_time,
   output logic [pps_pkg::SUM_W-1:0]       rsp_total_waiting,
   output logic [pps_pkg::SUM_W-1:0]       rsp_total_turnaround,
   output logic                            rsp_last_result
);

   localparam int IDX_W  = $clog2(MAX_PROCS);
   localparam int LD_W   = $clog2(MAX_PROCS + 1);
   localparam int TICK_W = $clog2(256 * (MAX_PROCS + 1));

   pps_pkg::state_type    state_ff, state_in;
   logic [LD_W-1:0]       loaded_ff, loaded_in;
   logic [LD_W-1:0]       finished_ff, finished_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [IDX_W-1:0]      out_idx_ff, out_idx_in;

   pps_pkg::cell_ctl_type cell_ctl;
   pps_pkg::rpt_ctl_type  rpt_ctl;
   pps_pkg::slot_type     new_slot;

   pps_pkg::slot_type     cell_slot  [MAX_PROCS];
   logic [MAX_PROCS-1:0]  cell_valid, cell_keep, fin_vec;
   logic [MAX_PROCS:0]    busy_chain;
   logic [pps_pkg::TAG_W-1:0] fin_tag_arr  [MAX_PROCS];
   logic [TICK_W-1:0]         fin_turn_arr [MAX_PROCS];
   logic [TICK_W-1:0]         fin_wait_arr [MAX_PROCS];

   logic [pps_pkg::TAG_W-1:0] fin_tag;
   logic [TICK_W-1:0]         fin_turn, fin_wait;
   logic                      any_finish, req_acc, out_last;

   assign req_ready = (state_ff == pps_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == pps_pkg::ST_SHOW);
   assign req_acc   = req_valid && req_ready;
   assign out_last  = (LD_W'(out_idx_ff) + LD_W'(1)) == loaded_ff;

   // incoming process, zero burst counted as one
   always_comb begin
      new_slot.tag       = pps_pkg::TAG_W'(loaded_ff);
      new_slot.burst     = (req_burst_time == '0) ? 8'd1 : req_burst_time;
      new_slot.arrival   = req_arrival_time;
      new_slot.prio      = req_priority_req;
      new_slot.remaining = new_slot.burst;
   end

   // cell chain
   assign busy_chain[0] = 1'b0;

   for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
      pps_pkg::slot_type prev_slot;
      logic              prev_valid, prev_keep;
      if (i == 0) begin : g_head
         assign prev_slot  = new_slot;
         assign prev_valid = 1'b0;
         assign prev_keep  = 1'b1;
      end else begin : g_body
         assign prev_slot  = cell_slot[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_keep  = cell_keep[i-1];
      end
      pps_cell #(
         .TICK_W (TICK_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .new_slot   (new_slot),
         .tick       (tick_ff),
         .prev_slot  (prev_slot),
         .prev_valid (prev_valid),
         .prev_keep  (prev_keep),
         .busy_in    (busy_chain[i]),
         .slot_out   (cell_slot[i]),
         .valid_out  (cell_valid[i]),
         .keep_out   (cell_keep[i]),
         .busy_out   (busy_chain[i+1]),
         .finish     (fin_vec[i]),
         .fin_tag    (fin_tag_arr[i]),
         .fin_turn   (fin_turn_arr[i]),
         .fin_wait   (fin_wait_arr[i])
      );
   end

   // merge the single completion record of this tick
   always_comb begin
      fin_tag  = '0;
      fin_turn = '0;
      fin_wait = '0;
      for (int i = 0; i < MAX_PROCS; i++) begin
         fin_tag  = fin_tag  | fin_tag_arr[i];
         fin_turn = fin_turn | fin_turn_arr[i];
         fin_wait = fin_wait | fin_wait_arr[i];
      end
   end
   assign any_finish = |fin_vec;

   // sequencer: load, run ticks, report
   always_comb begin
      state_in    = state_ff;
      loaded_in   = loaded_ff;
      finished_in = finished_ff;
      tick_in     = tick_ff;
      out_idx_in  = out_idx_ff;
      cell_ctl    = '0;
      rpt_ctl     = '0;
      rpt_ctl.last = out_last;
      case (state_ff)
         pps_pkg::ST_IDLE: begin
            rpt_ctl.clear_totals = 1'b1;
            if (req_acc) begin
               if (loaded_ff < LD_W'(MAX_PROCS)) begin
                  cell_ctl.load = 1'b1;
                  loaded_in     = loaded_ff + LD_W'(1);
               end
               if (req_last_process) begin
                  state_in = pps_pkg::ST_RUN;
               end
            end
         end
         pps_pkg::ST_RUN: begin
            cell_ctl.run = 1'b1;
            tick_in      = tick_ff + TICK_W'(1);
            if (any_finish) begin
               rpt_ctl.wr_en = 1'b1;
               finished_in   = finished_ff + LD_W'(1);
               if (finished_in == loaded_ff) begin
                  state_in = pps_pkg::ST_READ;
               end
            end
         end
         pps_pkg::ST_READ: begin
            state_in = pps_pkg::ST_LATCH;
         end
         pps_pkg::ST_LATCH: begin
            rpt_ctl.latch = 1'b1;
            state_in      = pps_pkg::ST_SHOW;
         end
         pps_pkg::ST_SHOW: begin
            if (rsp_ready) begin
               if (out_last) begin
                  state_in       = pps_pkg::ST_IDLE;
                  loaded_in      = '0;
                  finished_in    = '0;
                  tick_in        = '0;
                  out_idx_in     = '0;
                  cell_ctl.clear = 1'b1;
               end else begin
                  out_idx_in = out_idx_ff + IDX_W'(1);
                  state_in   = pps_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = pps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pps_pkg::ST_IDLE;
         loaded_ff   <= '0;
         finished_ff <= '0;
         tick_ff     <= '0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         loaded_ff   <= loaded_in;
         finished_ff <= finished_in;
         tick_ff     <= tick_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   pps_report #(
      .MAX_PROCS (MAX_PROCS),
      .TICK_W    (TICK_W),
      .IDX_W     (IDX_W)
   ) u_report (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (rpt_ctl),
      .wr_addr              (IDX_W'(fin_tag)),
      .wr_turn              (fin_turn),
      .wr_wait              (fin_wait),
      .rd_addr              (out_idx_ff),
      .rsp_process_index    (rsp_process_index),
      .rsp_waiting_time     (rsp_waiting_time),
      .rsp_turnaround_time  (rsp_turnaround_time),
      .rsp_total_waiting    (rsp_total_waiting),
      .rsp_total_turnaround (rsp_total_turnaround),
      .rsp_last_result      (rsp_last_result)
   );

   // at most one process finishes per tick
   assert property (@(posedge clock) disable iff (reset) $onehot0(fin_vec))
      else $error("more than one cell finished in one tick");

   // finished count never passes loaded count
   assert property (@(posedge clock) disable iff (reset) finished_ff <= loaded_ff)
      else $error("finished count exceeds loaded count");

   // a simulation always has at least one process
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pps_pkg::ST_RUN) |-> (loaded_ff != '0))
      else $error("tick loop running on an empty set");

   // the report pass starts only once every process has finished
   assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == pps_pkg::ST_RUN && state_ff == pps_pkg::ST_READ)
      |-> (finished_ff == loaded_ff))
      else $error("report started before all processes finished");

   // no cell runs outside the tick loop
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != pps_pkg::ST_RUN) |-> (fin_vec == '0))
      else $error("cell finished outside the tick loop");

endmodule

// ===== sv/pps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_cell: one slot of the priority-sorted process chain
// Holds one process. Cells stay sorted by priority (high first, then load
// order); a new item is inserted by shifting the lower part of the chain down.
// On each tick the first ready cell in the chain takes the processor.
// ----------------------------------------------------------------------------
module pps_cell #(
   parameter int TICK_W = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pps_pkg::cell_ctl_type       ctl,
   input  pps_pkg::slot_type           new_slot,
   input  logic [TICK_W-1:0]           tick,
   input  pps_pkg::slot_type           prev_slot,
   input  logic                        prev_valid,
   input  logic                        prev_keep,
   input  logic                        busy_in,
   output pps_pkg::slot_type           slot_out,
   output logic                        valid_out,
   output logic                        keep_out,
   output logic                        busy_out,
   output logic                        finish,
   output logic [pps_pkg::TAG_W-1:0]   fin_tag,
   output logic [TICK_W-1:0]           fin_turn,
   output logic [TICK_W-1:0]           fin_wait
);

   pps_pkg::slot_type slot_ff, slot_in;
   logic              valid_ff, valid_in;
   logic [TICK_W-1:0] arr_ext, burst_ext, turn_calc;
   logic              keep, ready, grant;

   assign arr_ext   = {{(TICK_W-pps_pkg::FIELD_W){1'b0}}, slot_ff.arrival};
   assign burst_ext = {{(TICK_W-pps_pkg::FIELD_W){1'b0}}, slot_ff.burst};

   // stay in place when at least as urgent as the incoming item
   assign keep     = valid_ff && (slot_ff.prio >= new_slot.prio);
   assign keep_out = keep;

   // arbitrate: first ready cell down the chain wins
   assign ready    = valid_ff && (slot_ff.remaining != '0) && (tick >= arr_ext);
   assign grant    = ctl.run && ready && !busy_in;
   assign busy_out = busy_in | ready;

   // completion record, zero unless this cell finishes on this tick
   assign finish    = grant && (slot_ff.remaining == 8'd1);
   assign turn_calc = tick + {{(TICK_W-1){1'b0}}, 1'b1} - arr_ext;
   assign fin_turn  = finish ? turn_calc : '0;
   assign fin_wait  = finish ? (turn_calc - burst_ext) : '0;
   assign fin_tag   = finish ? slot_ff.tag : '0;

   assign slot_out  = slot_ff;
   assign valid_out = valid_ff;

   // clear, insert, shift down or run one tick
   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.load) begin
         if (!keep) begin
            if (prev_keep) begin
               slot_in  = new_slot;
               valid_in = 1'b1;
            end else begin
               slot_in  = prev_slot;
               valid_in = prev_valid;
            end
         end
      end else if (grant) begin
         slot_in.remaining = slot_ff.remaining - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// ===== sv/pps_report.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_report: completion store and result formatting
// Records turnaround and waiting per process at its load index as it
// finishes, then reads them back in index order and keeps running totals.
// ----------------------------------------------------------------------------
module pps_report #(
   parameter int MAX_PROCS = 16,
   parameter int TICK_W    = 13,
   parameter int IDX_W     = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pps_pkg::rpt_ctl_type            ctl,
   input  logic [IDX_W-1:0]                wr_addr,
   input  logic [TICK_W-1:0]               wr_turn,
   input  logic [TICK_W-1:0]               wr_wait,
   input  logic [IDX_W-1:0]                rd_addr,
   output logic [pps_pkg::IDX_OUT_W-1:0]   rsp_process_index,
   output logic [pps_pkg::OUT_W-1:0]       rsp_waiting_time,
   output logic [pps_pkg::OUT_W-1:0]       rsp_turnaround_time,
   output logic [pps_pkg::SUM_W-1:0]       rsp_total_waiting,
   output logic [pps_pkg::SUM_W-1:0]       rsp_total_turnaround,
   output logic                            rsp_last_result
);

   localparam int WIDE_W = TICK_W + pps_pkg::SUM_W;
   localparam int IWIDE_W = IDX_W + pps_pkg::IDX_OUT_W;

   logic [2*TICK_W-1:0] mem [MAX_PROCS];
   logic [2*TICK_W-1:0] rd_data_ff;

   logic [pps_pkg::SUM_W-1:0] tot_wait_ff, tot_wait_in;
   logic [pps_pkg::SUM_W-1:0] tot_turn_ff, tot_turn_in;

   logic [pps_pkg::IDX_OUT_W-1:0] idx_ff;
   logic [pps_pkg::OUT_W-1:0]     wait_ff, turn_ff;
   logic [pps_pkg::SUM_W-1:0]     sum_wait_ff, sum_turn_ff;
   logic                          last_ff;

   logic [WIDE_W-1:0]  wait_wide, turn_wide;
   logic [IWIDE_W-1:0] idx_wide;

   // write on completion, registered read for the report pass
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= {wr_turn, wr_wait};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign turn_wide = {{pps_pkg::SUM_W{1'b0}}, rd_data_ff[2*TICK_W-1:TICK_W]};
   assign wait_wide = {{pps_pkg::SUM_W{1'b0}}, rd_data_ff[TICK_W-1:0]};
   assign idx_wide  = {{pps_pkg::IDX_OUT_W{1'b0}}, rd_addr};

   assign tot_wait_in = tot_wait_ff + wait_wide[pps_pkg::SUM_W-1:0];
   assign tot_turn_in = tot_turn_ff + turn_wide[pps_pkg::SUM_W-1:0];

   // accumulate totals per result, clear between sets
   always_ff @(posedge clock) begin
      if (reset || ctl.clear_totals) begin
         tot_wait_ff <= '0;
         tot_turn_ff <= '0;
      end else if (ctl.latch) begin
         tot_wait_ff <= tot_wait_in;
         tot_turn_ff <= tot_turn_in;
      end
   end

   // hold the result fields for the output handshake
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         idx_ff      <= idx_wide[pps_pkg::IDX_OUT_W-1:0];
         wait_ff     <= wait_wide[pps_pkg::OUT_W-1:0];
         turn_ff     <= turn_wide[pps_pkg::OUT_W-1:0];
         sum_wait_ff <= tot_wait_in;
         sum_turn_ff <= tot_turn_in;
         last_ff     <= ctl.last;
      end
   end

   assign rsp_process_index    = idx_ff;
   assign rsp_waiting_time     = wait_ff;
   assign rsp_turnaround_time  = turn_ff;
   assign rsp_total_waiting    = sum_wait_ff;
   assign rsp_total_turnaround = sum_turn_ff;
   assign rsp_last_result      = last_ff;

endmodule

// ===== dv/schedule_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schedule_checker: predicts and checks the scheduler's report items
// Keeps its own copy of the open process set from the accepted request items.
// When a closing item is taken it replays the unit-tick schedule and queues one
// expected report per held process. Each report item taken on the response
// channel is then compared field by field with the oldest expected report.
// ----------------------------------------------------------------------------
module schedule_checker #(
   parameter int MAX_PROCS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_burst_time,
   input  logic [7:0]                      req_arrival_time,
   input  logic [7:0]                      req_priority_req,
   input  logic                            req_last_process,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [pps_pkg::IDX_OUT_W-1:0]   rsp_process_index,
   input  logic [pps_pkg::OUT_W-1:0]       rsp_waiting_time,
   input  logic [pps_pkg::OUT_W-1:0]       rsp_turnaround_time,
   input  logic [pps_pkg::SUM_W-1:0]       rsp_total_waiting,
   input  logic [pps_pkg::SUM_W-1:0]       rsp_total_turnaround,
   input  logic                            rsp_last_result,
   output int                              mismatch_count,
   output int                              outstanding_reports
);

   // one expected report item
   typedef struct packed {
      logic [pps_pkg::IDX_OUT_W-1:0] index;
      logic [pps_pkg::OUT_W-1:0]     waiting;
      logic [pps_pkg::OUT_W-1:0]     turnaround;
      logic [pps_pkg::SUM_W-1:0]     total_waiting;
      logic [pps_pkg::SUM_W-1:0]     total_turnaround;
      logic                          last;
   } report_type;

   // process set being loaded
   logic [pps_pkg::FIELD_W-1:0] set_burst      [MAX_PROCS];
   logic [pps_pkg::FIELD_W-1:0] set_arrival    [MAX_PROCS];
   logic [pps_pkg::FIELD_W-1:0] set_prio       [MAX_PROCS];
   logic [pps_pkg::FIELD_W-1:0] set_remaining  [MAX_PROCS];
   logic [pps_pkg::OUT_W-1:0]   set_completion [MAX_PROCS];
   int                          set_size;

   report_type expected_reports [$];

   // Replay the schedule of the held set and queue its reports in load order
   function automatic void schedule_set();
      logic [pps_pkg::OUT_W-1:0] tick;
      logic [pps_pkg::OUT_W-1:0] turnaround;
      logic [pps_pkg::OUT_W-1:0] waiting;
      logic [pps_pkg::SUM_W-1:0] sum_wait;
      logic [pps_pkg::SUM_W-1:0] sum_turn;
      int                        done;
      int                        best;
      int                        k;
      bit                        found;
      report_type                rpt;
      tick     = '0;
      done     = 0;
      sum_wait = '0;
      sum_turn = '0;
      // run the highest ready priority for one tick; ties go to the lowest index
      while (done < set_size) begin
         found = 1'b0;
         best  = 0;
         for (k = 0; k < set_size; k++) begin
            if (pps_pkg::OUT_W'(set_arrival[k]) <= tick && set_remaining[k] != '0) begin
               if (!found || set_prio[k] > set_prio[best]) begin
                  best  = k;
                  found = 1'b1;
               end
            end
         end
         if (found) begin
            set_remaining[best] = set_remaining[best] - 8'd1;
            if (set_remaining[best] == '0) begin
               set_completion[best] = tick + pps_pkg::OUT_W'(1);
               done++;
            end
         end
         tick = tick + pps_pkg::OUT_W'(1);
      end
      // build the reports with running totals
      for (k = 0; k < set_size; k++) begin
         turnaround           = set_completion[k] - pps_pkg::OUT_W'(set_arrival[k]);
         waiting              = turnaround - pps_pkg::OUT_W'(set_burst[k]);
         sum_wait             = sum_wait + pps_pkg::SUM_W'(waiting);
         sum_turn             = sum_turn + pps_pkg::SUM_W'(turnaround);
         rpt.index            = pps_pkg::IDX_OUT_W'(k);
         rpt.waiting          = waiting;
         rpt.turnaround       = turnaround;
         rpt.total_waiting    = sum_wait;
         rpt.total_turnaround = sum_turn;
         rpt.last             = (k == set_size - 1);
         expected_reports.push_back(rpt);
      end
   endfunction

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         set_size       = 0;
         mismatch_count = 0;
         expected_reports.delete();
      end else begin
         // compare the report item taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected report item, process_index %0d", rsp_process_index);
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("process_index", longint'(want.index),
                           longint'(rsp_process_index));
               check_field("waiting_time", longint'(want.waiting),
                           longint'(rsp_waiting_time));
               check_field("turnaround_time", longint'(want.turnaround),
                           longint'(rsp_turnaround_time));
               check_field("total_waiting", longint'(want.total_waiting),
                           longint'(rsp_total_waiting));
               check_field("total_turnaround", longint'(want.total_turnaround),
                           longint'(rsp_total_turnaround));
               check_field("last_result", longint'(want.last),
                           longint'(rsp_last_result));
            end
         end
         // load the process item; drop it once the set is full
         if (req_valid && req_ready) begin
            if (set_size < MAX_PROCS) begin
               set_burst[set_size]     = (req_burst_time == '0) ? 8'd1 : req_burst_time;
               set_arrival[set_size]   = req_arrival_time;
               set_prio[set_size]      = req_priority_req;
               set_remaining[set_size] = set_burst[set_size];
               set_size++;
            end
            // a closing item starts the run even when it was dropped
            if (req_last_process) begin
               schedule_set();
               set_size = 0;
            end
         end
      end
      outstanding_reports = expected_reports.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: process set stimulus for the preemptive priority scheduler
// Sends directed sets (field extremes, zero burst, priority ties, preemption,
// idle ticks, set overflow) and then random sets, mostly with short bursts.
// Both channels idle at random in the first two of three phases; a separate
// checker predicts every report item and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NUM_SLOTS    = 16;
   localparam int RANDOM_ITEMS = 236;
   localparam int STALL_LIMIT  = 25000;
   localparam int DRAIN_CYCLES = 50;

   logic clock            = 1'b0;
   logic reset            = 1'b1;
   logic req_valid        = 1'b0;
   logic [7:0] req_burst_time   = '0;
   logic [7:0] req_arrival_time = '0;
   logic [7:0] req_priority_req = '0;
   logic req_last_process = 1'b0;
   logic rsp_ready        = 1'b0;
   logic req_ready;
   logic rsp_valid;
   logic [pps_pkg::IDX_OUT_W-1:0] rsp_process_index;
   logic [pps_pkg::OUT_W-1:0]     rsp_waiting_time;
   logic [pps_pkg::OUT_W-1:0]     rsp_turnaround_time;
   logic [pps_pkg::SUM_W-1:0]     rsp_total_waiting;
   logic [pps_pkg::SUM_W-1:0]     rsp_total_turnaround;
   logic                          rsp_last_result;

   int mismatch_count;
   int outstanding_reports;
   int send_idle_pct = 27;
   int recv_idle_pct = 62;
   int stall_cycles  = 0;
   int items_sent    = 0;

   preemptive_priority_scheduler #(.MAX_PROCS(NUM_SLOTS)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_burst_time       (req_burst_time),
      .req_arrival_time     (req_arrival_time),
      .req_priority_req     (req_priority_req),
      .req_last_process     (req_last_process),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_process_index    (rsp_process_index),
      .rsp_waiting_time     (rsp_waiting_time),
      .rsp_turnaround_time  (rsp_turnaround_time),
      .rsp_total_waiting    (rsp_total_waiting),
      .rsp_total_turnaround (rsp_total_turnaround),
      .rsp_last_result      (rsp_last_result)
   );

   schedule_checker #(.MAX_PROCS(NUM_SLOTS)) report_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_burst_time       (req_burst_time),
      .req_arrival_time     (req_arrival_time),
      .req_priority_req     (req_priority_req),
      .req_last_process     (req_last_process),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_process_index    (rsp_process_index),
      .rsp_waiting_time     (rsp_waiting_time),
      .rsp_turnaround_time  (rsp_turnaround_time),
      .rsp_total_waiting    (rsp_total_waiting),
      .rsp_total_turnaround (rsp_total_turnaround),
      .rsp_last_result      (rsp_last_result),
      .mismatch_count       (mismatch_count),
      .outstanding_reports  (outstanding_reports)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // stall the response channel at random
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // end the run when nothing is taken on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one process item after a random gap and hold it until taken
   task automatic send_process(input logic [7:0] burst, input logic [7:0] arrival,
                               input logic [7:0] prio, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_burst_time   <= burst;
      req_arrival_time <= arrival;
      req_priority_req <= prio;
      req_last_process <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Hold off the sender until every expected report has come back
   task automatic drain_reports();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding_reports != 0) @(negedge clock);
   endtask

   // Send one closed set; a few overflow, a quarter use the full field range
   task automatic send_random_set();
      int count;
      int i;
      bit wide;
      if ($urandom_range(9) == 0) begin
         count = $urandom_range(NUM_SLOTS + 3, NUM_SLOTS + 1);
      end else begin
         count = $urandom_range(NUM_SLOTS, 1);
      end
      wide = ($urandom_range(3) == 0);
      for (i = 0; i < count; i++) begin
         if (wide) begin
            send_process(8'($urandom_range(255, 1)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), i == count - 1);
         end else begin
            send_process(8'($urandom_range(12, 1)), 8'($urandom_range(24)),
                         8'($urandom_range(3)), i == count - 1);
         end
      end
      if ($urandom_range(3) == 0) begin
         drain_reports();
      end
   endtask

   initial begin
      int i;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lone process at the field maxima
      send_process(8'd255, 8'd255, 8'd255, 1'b1);
      drain_reports();

      // zero burst, priority tie at zero, a late high-priority arrival, then idle ticks
      send_process(8'd1, 8'd0, 8'd0, 1'b0);
      send_process(8'd0, 8'd0, 8'd0, 1'b0);
      send_process(8'd3, 8'd2, 8'd200, 1'b0);
      send_process(8'd2, 8'd10, 8'd0, 1'b1);
      drain_reports();

      // fill the set and overflow it; the dropped closing item still starts the run
      for (i = 0; i < NUM_SLOTS + 3; i++) begin
         send_process(8'(i * 16 + 15), 8'(i * 3), 8'(i % 4 * 85), i == NUM_SLOTS + 2);
      end
      drain_reports();

      // random sets over three phases, the last without idling
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (items_sent >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 62;
            recv_idle_pct = 27;
         end
         send_random_set();
      end

      drain_reports();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/pps_pkg.sv
sv/pps_cell.sv
sv/pps_report.sv
sv/preemptive_priority_scheduler.sv
dv/schedule_checker.sv
dv/testbench.sv
